// ===== sv/bam_pkg.sv =====
// Shared types, constants and fixed-point helpers for the biometric affect mapper.
// Depends on nothing; used by biometric_affect_mapper and the testbench.
package bam_pkg;

  localparam int NFIELDS = 5;
  localparam int ENTRY_W = 17;
  localparam int F_TEMP  = 3;

  localparam logic [15:0] Q_ONE  = 16'd32768;
  localparam logic [15:0] Q_HALF = 16'd16384;

  localparam logic REG_ENABLE = 1'b0;

  typedef struct packed {
    logic               hr_present;
    logic        [15:0] heart_rate;
    logic               hrv_present;
    logic        [15:0] hrv_ms;
    logic               eda_present;
    logic        [15:0] conductance;
    logic               temp_present;
    logic signed [15:0] body_temp;
    logic               motion_present;
    logic        [15:0] motion_level;
  } in_t;

  typedef struct packed {
    logic signed [15:0] valence;
    logic        [15:0] arousal;
    logic        [15:0] intensity;
    logic        [4:0]  avg_mask;
    logic        [15:0] avg_heart_rate;
    logic        [15:0] avg_hrv;
    logic        [15:0] avg_conductance;
    logic signed [15:0] avg_temp;
    logic        [15:0] avg_motion;
  } out_t;

  // One window slot: per field a valid bit above a 16-bit raw value.
  typedef logic [NFIELDS-1:0][ENTRY_W-1:0] entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPD,
    S_DIVGO,
    S_DIVWAIT,
    S_DONE
  } state_e;

  // Constant divisions by reciprocal multiplication, exact over the stated ranges.
  function automatic logic [15:0] div5(input logic [17:0] x);
    logic [35:0] p;
    p = 36'(x) * 36'd209716;
    return p[35:20];
  endfunction

  function automatic logic [13:0] div25(input logic [17:0] x);
    logic [36:0] p;
    p = 37'(x) * 37'd335545;
    return p[36:23];
  endfunction

  function automatic logic [13:0] div15_short(input logic [16:0] x);
    logic [35:0] p;
    p = 36'(x) * 36'd279621;
    return p[35:22];
  endfunction

  function automatic logic [15:0] div15_long(input logic [18:0] x);
    logic [39:0] p;
    p = 40'(x) * 40'd1118482;
    return p[39:24];
  endfunction

endpackage

// ===== sv/bam_div.sv =====
// Restoring divider producing a 16-bit quotient, one bit per cycle.
// Depends on nothing; the quotient must be known to fit in 16 bits.
module bam_div #(
  parameter int CW = 6,
  parameter int MW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [15:0]   quotient_o
);

  logic          busy_q, done_q;
  logic [3:0]    step_q;
  logic [CW-1:0] rem_q, div_q;
  logic [15:0]   low_q;
  logic [CW:0]   shifted, trial;
  logic          ge;

  assign shifted = {rem_q, low_q[15]};
  assign ge      = shifted >= {1'b0, div_q};
  assign trial   = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[MW-1:16];
      low_q <= dividend_i[15:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[CW-1:0] : shifted[CW-1:0];
      low_q <= {low_q[14:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = low_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
`endif

endmodule

// ===== sv/biometric_affect_mapper.sv =====
// Top level of the biometric affect mapper: configuration port, window memory,
// affect arithmetic and window averaging. Uses bam_pkg and bam_div.
// An enabled item passes through the read, update and divide states before its
// result is offered; a disabled item goes straight to the done state. One item is in
// work at a time, so a new item is taken only once the previous one has reached the
// result register; the five window divisions share one divider.
// Reset clears enable, window sums, counts, write slot and fill level; the
// window memory itself is not cleared, since only written slots are read.
module biometric_affect_mapper #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bam_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bam_pkg::out_t out_o
);

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int MW = 16 + CW;
  localparam int SW = MW + 1;
  localparam int NF = bam_pkg::NFIELDS;

  // Configuration register.
  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == bam_pkg::REG_ENABLE)) begin
      enable_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {31'd0, enable_q};

  // Control.
  bam_pkg::state_e state_q, state_d;
  logic            accept, mem_we, div_start, load_out, out_valid_q;
  logic [2:0]      f_q;

  assign accept     = in_valid_i && (state_q == bam_pkg::S_IDLE);
  assign in_stall_o = state_q != bam_pkg::S_IDLE;

  logic div_done;

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      bam_pkg::S_IDLE: begin
        if (in_valid_i) state_d = enable_q ? bam_pkg::S_READ : bam_pkg::S_DONE;
      end
      bam_pkg::S_READ: state_d = bam_pkg::S_UPD;
      bam_pkg::S_UPD: begin
        mem_we  = 1'b1;
        state_d = bam_pkg::S_DIVGO;
      end
      bam_pkg::S_DIVGO: begin
        div_start = 1'b1;
        state_d   = bam_pkg::S_DIVWAIT;
      end
      bam_pkg::S_DIVWAIT: begin
        if (div_done) state_d = (f_q == 3'(NF - 1)) ? bam_pkg::S_DONE : bam_pkg::S_DIVGO;
      end
      bam_pkg::S_DONE: begin
        // The result register takes the item once the previous one has left.
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = bam_pkg::S_IDLE;
        end
      end
      default: state_d = bam_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bam_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // Captured item and per-field views of it.
  bam_pkg::in_t   in_q;
  logic           en_item_q;
  logic [NF-1:0]  pres;
  logic [15:0]    raw [NF];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q      <= in_i;
      en_item_q <= enable_q;
    end
  end

  assign pres   = {in_q.motion_present, in_q.temp_present, in_q.eda_present,
                   in_q.hrv_present, in_q.hr_present};
  assign raw[0] = in_q.heart_rate;
  assign raw[1] = in_q.hrv_ms;
  assign raw[2] = in_q.conductance;
  assign raw[3] = in_q.body_temp;
  assign raw[4] = in_q.motion_level;

  // Affect arithmetic, first stage: heart-rate arousal, the two intensity
  // candidates and valence, all from the raw readings.
  logic [15:0] h, v, c;
  logic [10:0] d1, d2;
  logic [15:0] d3;
  logic [9:0]  d3c;
  logic [17:0] x1, x2;
  logic [16:0] x3;
  logic [13:0] q3;
  logic [15:0] hr_ar;
  logic [11:0] vc;
  logic [15:0] hrv_t, hrvi;
  logic [12:0] cc;
  logic [15:0] edai;
  logic signed [16:0] tdiff;
  logic signed [22:0] tscaled;
  logic signed [15:0] val;

  always_comb begin
    h   = in_q.heart_rate;
    v   = in_q.hrv_ms;
    c   = in_q.conductance;
    d1  = 11'(h - 16'd3840);
    d2  = 11'(h - 16'd5120);
    d3  = h - 16'd6400;
    d3c = (d3 > 16'd800) ? 10'd800 : d3[9:0];
    x1  = {d1, 7'd0};
    x2  = {d2, 7'd0} + {1'b0, d2, 6'd0};
    x3  = {d3c, 7'd0};
    q3  = bam_pkg::div15_short(x3);
    // Heart rate segments: below 60, 60 to 80, 80 to 100 and above 100 bpm.
    if (h < 16'd3840)      hr_ar = 16'd6554;
    else if (h < 16'd5120) hr_ar = 16'd9830 + 16'(bam_pkg::div25(x1));
    else if (h < 16'd6400) hr_ar = 16'd16384 + 16'(bam_pkg::div25(x2));
    else                   hr_ar = 16'd26214 + ((q3 > 14'd6554) ? 16'd6554 : 16'(q3));

    vc    = (v > 16'd3840) ? 12'd3840 : v[11:0];
    hrv_t = bam_pkg::div15_long({vc, 7'd0});
    hrvi  = (hrv_t >= bam_pkg::Q_ONE) ? 16'd0 : 16'(bam_pkg::Q_ONE - hrv_t);

    cc   = (c > 16'd5120) ? 13'd5120 : c[12:0];
    edai = bam_pkg::div5({cc, 5'd0});

    tdiff   = {in_q.body_temp[15], in_q.body_temp} - 17'sd9216;
    tscaled = {tdiff, 6'd0};
    if (tscaled > 23'sd32767)       val = 16'sh7fff;
    else if (tscaled < -23'sd32768) val = 16'sh8000;
    else                            val = tscaled[15:0];
  end

  logic [15:0]        ar_a_q, hrvi_a_q, edai_a_q;
  logic signed [15:0] val_a_q;

  always_ff @(posedge clk_i) begin
    if (state_q == bam_pkg::S_READ) begin
      ar_a_q   <= in_q.hr_present ? hr_ar : bam_pkg::Q_HALF;
      hrvi_a_q <= hrvi;
      edai_a_q <= edai;
      val_a_q  <= in_q.temp_present ? val : 16'sd0;
    end
  end

  // Second stage: variability scaling of arousal, movement blend, intensity.
  logic [15:0] ar_b, ar_m, ar_fin, int_fin, a45, a65;
  logic [17:0] mix, isum;

  always_comb begin
    a45 = bam_pkg::div5({ar_a_q, 2'd0});
    a65 = bam_pkg::div5({ar_a_q, 2'd0} + {1'b0, ar_a_q, 1'd0});
    ar_b = ar_a_q;
    if (in_q.hrv_present) begin
      if (in_q.hrv_ms > 16'd2560)      ar_b = a45;
      else if (in_q.hrv_ms < 16'd1280) ar_b = (a65 > bam_pkg::Q_ONE) ? bam_pkg::Q_ONE : a65;
    end
    mix  = {1'b0, ar_b, 1'b0} + {2'd0, in_q.motion_level};
    ar_m = in_q.motion_present ? mix[17:2] : ar_b;
    ar_fin = (ar_m > bam_pkg::Q_ONE) ? bam_pkg::Q_ONE : ar_m;

    isum = {2'd0, edai_a_q} + {2'd0, hrvi_a_q};
    priority if (in_q.hrv_present && in_q.eda_present) int_fin = isum[16:1];
    else if (in_q.hrv_present)                         int_fin = hrvi_a_q;
    else if (in_q.eda_present)                         int_fin = edai_a_q;
    else                                               int_fin = bam_pkg::Q_HALF;
  end

  logic [15:0]        ar_q, int_q;
  logic signed [15:0] val_q;

  always_ff @(posedge clk_i) begin
    if (state_q == bam_pkg::S_UPD) begin
      ar_q  <= ar_fin;
      int_q <= int_fin;
      val_q <= val_a_q;
    end
  end

  // Window memory: one slot holds all five fields of one sample.
  bam_pkg::entry_t mem [WINDOW_DEPTH];
  bam_pkg::entry_t rd_q, wr_entry;
  logic [AW-1:0]   slot_q;
  logic [CW-1:0]   fill_q;
  logic            full;

  assign full = fill_q == CW'(WINDOW_DEPTH);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[slot_q] <= wr_entry;
    if (accept) rd_q <= mem[slot_q];
  end

  // Running sums and counts: drop the overwritten sample once the window is
  // full, then add the new one.
  logic signed [SW-1:0] sums_q [NF];
  logic signed [SW-1:0] sums_d [NF];
  logic [CW-1:0]        counts_q [NF];
  logic [CW-1:0]        counts_d [NF];

  always_comb begin
    for (int f = 0; f < NF; f++) begin
      logic                 old_ok;
      logic signed [SW-1:0] old_val, new_val;
      old_ok  = full && rd_q[f][16];
      old_val = (f == bam_pkg::F_TEMP) ? SW'($signed(rd_q[f][15:0]))
                                       : SW'($signed({1'b0, rd_q[f][15:0]}));
      new_val = (f == bam_pkg::F_TEMP) ? SW'($signed(raw[f]))
                                       : SW'($signed({1'b0, raw[f]}));
      sums_d[f]   = sums_q[f] - (old_ok ? old_val : '0) + (pres[f] ? new_val : '0);
      counts_d[f] = counts_q[f] - CW'(old_ok) + CW'(pres[f]);
      wr_entry[f] = pres[f] ? {1'b1, raw[f]} : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < NF; f++) begin
        sums_q[f]   <= '0;
        counts_q[f] <= '0;
      end
      slot_q <= '0;
      fill_q <= '0;
    end else if (mem_we) begin
      for (int f = 0; f < NF; f++) begin
        sums_q[f]   <= sums_d[f];
        counts_q[f] <= counts_d[f];
      end
      slot_q <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + AW'(1);
      if (!full) fill_q <= fill_q + CW'(1);
    end
  end

  // Window means: the five fields take turns on one divider; a negative
  // temperature sum is divided as a magnitude and the quotient negated.
  logic [SW-1:0] mag;
  logic          neg;
  logic [15:0]   quot;
  logic [15:0]   avg_q [NF];

  assign neg = sums_q[f_q][SW-1];
  assign mag = neg ? SW'(-sums_q[f_q]) : SW'(sums_q[f_q]);

  bam_div #(.CW(CW), .MW(MW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag[MW-1:0]),
    .divisor_i  (counts_q[f_q]),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (state_q == bam_pkg::S_UPD) begin
      f_q <= '0;
    end else if (state_q == bam_pkg::S_DIVWAIT && div_done) begin
      f_q <= f_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bam_pkg::S_DIVWAIT && div_done) begin
      avg_q[f_q] <= (counts_q[f_q] == '0) ? 16'd0 : (neg ? 16'(-quot) : quot);
    end
  end

  // Result register. A disabled item gets the neutral answer with no averages.
  bam_pkg::out_t out_q, out_d;
  logic [NF-1:0] mask;

  always_comb begin
    for (int f = 0; f < NF; f++) mask[f] = counts_q[f] != '0;
  end

  always_comb begin
    out_d           = '0;
    out_d.arousal   = bam_pkg::Q_HALF;
    out_d.intensity = bam_pkg::Q_HALF;
    if (en_item_q) begin
      out_d.valence         = val_q;
      out_d.arousal         = ar_q;
      out_d.intensity       = int_q;
      out_d.avg_mask        = mask;
      out_d.avg_heart_rate  = avg_q[0];
      out_d.avg_hrv         = avg_q[1];
      out_d.avg_conductance = avg_q[2];
      out_d.avg_temp        = avg_q[3];
      out_d.avg_motion      = avg_q[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WINDOW_DEPTH)) else $error("fill level beyond window depth");
  a_store_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> en_item_q) else $error("disabled item written to window");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == bam_pkg::S_DIVWAIT)) else $error("divider result unexpected");
  a_count_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (counts_q[0] <= fill_q) && (counts_q[3] <= fill_q))
    else $error("field count exceeds fill level");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for biometric_affect_mapper: random and directed samples
// checked against an in-bench affect and window-average predictor. Uses bam_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int LIMIT = 2000000;
  localparam int HOLD_CYCLES = 600;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [0:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  bam_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  bam_pkg::out_t out_o;

  biometric_affect_mapper DUT (.*);

  // Predictor state: enable bit and the sample window.
  logic        en_mirror = 1'b0;
  logic [16:0] win_ring [bam_pkg::NFIELDS][DEPTH];
  longint      win_sum [bam_pkg::NFIELDS];
  int          win_cnt [bam_pkg::NFIELDS];
  int          win_slot, win_fill;

  bam_pkg::in_t  sample_queue[$];
  bam_pkg::out_t affect_expected[$];
  int     errors = 0;
  int     cycles = 0;
  int     samples_sent = 0;
  int     results_seen = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  task automatic queue_sample(input bam_pkg::in_t s);
    sample_queue.insert(sample_queue.size(), s);
  endtask

  function automatic int unsigned hr_to_arousal(input int unsigned h);
    int unsigned d;
    if (h < 3840) return 6554;
    if (h < 5120) return 9830 + (h - 3840) * 128 / 25;
    if (h < 6400) return 16384 + (h - 5120) * 192 / 25;
    d = (h - 6400) * 128 / 15;
    if (d > 6554) d = 6554;
    return 26214 + d;
  endfunction

  function automatic longint entry_val(input int f, input logic [15:0] v);
    return (f == bam_pkg::F_TEMP) ? longint'($signed(v)) : longint'(v);
  endfunction

  // Computes the result of one accepted sample and, when enabled, advances the window.
  function automatic bam_pkg::out_t predict_affect(input bam_pkg::in_t s);
    bam_pkg::out_t r;
    logic        pres [bam_pkg::NFIELDS];
    logic [15:0] raw [bam_pkg::NFIELDS];
    int unsigned ar, inten, eda, hrvi, t;
    int          tv;
    r = '0;
    pres = '{s.hr_present, s.hrv_present, s.eda_present, s.temp_present, s.motion_present};
    raw = '{s.heart_rate, s.hrv_ms, s.conductance, s.body_temp, s.motion_level};
    if (!en_mirror) begin
      r.arousal = bam_pkg::Q_HALF;
      r.intensity = bam_pkg::Q_HALF;
      return r;
    end
    ar = pres[0] ? hr_to_arousal(32'(raw[0])) : 16384;
    eda = 0;
    if (pres[2]) begin
      eda = raw[2] * 32 / 5;
      if (eda > 32768) eda = 32768;
    end
    if (pres[1]) begin
      if (raw[1] > 2560) ar = ar * 4 / 5;
      else if (raw[1] < 1280) begin
        ar = ar * 6 / 5;
        if (ar > 32768) ar = 32768;
      end
      t = raw[1] * 128 / 15;
      hrvi = (t >= 32768) ? 0 : 32768 - t;
      inten = pres[2] ? (eda + hrvi) / 2 : hrvi;
    end else begin
      inten = pres[2] ? eda : 16384;
    end
    if (pres[4]) ar = (2 * ar + raw[4]) / 4;
    if (pres[3]) begin
      tv = (int'($signed(raw[3])) - 9216) * 64;
      if (tv > 32767) tv = 32767;
      if (tv < -32768) tv = -32768;
      r.valence = tv[15:0];
    end
    if (ar > 32768) ar = 32768;
    if (inten > 32768) inten = 32768;
    r.arousal = ar[15:0];
    r.intensity = inten[15:0];
    // Window update: a full window drops its oldest sample first.
    for (int f = 0; f < bam_pkg::NFIELDS; f++) begin
      if (win_fill >= DEPTH && win_ring[f][win_slot][16]) begin
        win_sum[f] -= entry_val(f, win_ring[f][win_slot][15:0]);
        win_cnt[f]--;
      end
      if (pres[f]) begin
        win_ring[f][win_slot] = {1'b1, raw[f]};
        win_sum[f] += entry_val(f, raw[f]);
        win_cnt[f]++;
      end else begin
        win_ring[f][win_slot] = '0;
      end
    end
    if (win_fill < DEPTH) win_fill++;
    win_slot = (win_slot + 1) % DEPTH;
    for (int f = 0; f < bam_pkg::NFIELDS; f++) begin
      if (win_cnt[f] > 0) begin
        longint q;
        q = win_sum[f] / win_cnt[f];
        r.avg_mask[f] = 1'b1;
        case (f)
          0: r.avg_heart_rate = q[15:0];
          1: r.avg_hrv = q[15:0];
          2: r.avg_conductance = q[15:0];
          3: r.avg_temp = q[15:0];
          default: r.avg_motion = q[15:0];
        endcase
      end
    end
    return r;
  endfunction

  // Sender: offers queued samples, idling at random outside a steady stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    logic hold_item;
    bit   steady;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      hold_item = in_valid_i && in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        affect_expected.insert(affect_expected.size(), predict_affect(in_i));
        samples_sent <= samples_sent + 1;
      end
      steady = samples_sent >= 300 && samples_sent < 450;
      if (!hold_item) begin
        if (sample_queue.size() > 0 && (steady || $urandom_range(99) >= 28)) begin
          in_i <= sample_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch with no stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && samples_sent >= 600) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (results_seen >= 150 && results_seen < 300) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 28);
      end
    end
  end

  // Monitor: compares each delivered result with the oldest expectation.
  always @(posedge clk_i) begin
    bam_pkg::out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (affect_expected.size() == 0) begin
        report("result count", results_seen + 1, results_seen);
      end else begin
        w = affect_expected.pop_front();
        if (out_o.valence !== w.valence)
          report("valence", int'(out_o.valence), int'(w.valence));
        if (out_o.arousal !== w.arousal)
          report("arousal", int'(out_o.arousal), int'(w.arousal));
        if (out_o.intensity !== w.intensity)
          report("intensity", int'(out_o.intensity), int'(w.intensity));
        if (out_o.avg_mask !== w.avg_mask)
          report("avg_mask", int'(out_o.avg_mask), int'(w.avg_mask));
        if (out_o.avg_heart_rate !== w.avg_heart_rate)
          report("avg_heart_rate", int'(out_o.avg_heart_rate), int'(w.avg_heart_rate));
        if (out_o.avg_hrv !== w.avg_hrv)
          report("avg_hrv", int'(out_o.avg_hrv), int'(w.avg_hrv));
        if (out_o.avg_conductance !== w.avg_conductance)
          report("avg_conductance", int'(out_o.avg_conductance), int'(w.avg_conductance));
        if (out_o.avg_temp !== w.avg_temp)
          report("avg_temp", int'(out_o.avg_temp), int'(w.avg_temp));
        if (out_o.avg_motion !== w.avg_motion)
          report("avg_motion", int'(out_o.avg_motion), int'(w.avg_motion));
      end
    end
  end

  // Two-phase register write; the enable mirror follows at the access edge.
  task automatic write_enable(input logic val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= bam_pkg::REG_ENABLE;
    pwdata <= {31'd0, val};
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    en_mirror = val;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every queued sample was taken and every result came back.
  task automatic drain();
    while (sample_queue.size() > 0 || in_valid_i || affect_expected.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Mostly physiological values, now and then any value of the field.
  function automatic logic [15:0] pick(input int unsigned lo, input int unsigned hi);
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(hi, lo));
  endfunction

  function automatic bam_pkg::in_t random_sample();
    bam_pkg::in_t s;
    s.hr_present = $urandom_range(9) < 8;
    s.heart_rate = pick(2500, 8500);
    s.hrv_present = $urandom_range(9) < 7;
    s.hrv_ms = pick(0, 4500);
    s.eda_present = $urandom_range(9) < 7;
    s.conductance = pick(0, 6000);
    s.temp_present = $urandom_range(9) < 7;
    s.body_temp = $urandom_range(1) ? pick(8700, 9800) : 16'($urandom);
    s.motion_present = $urandom_range(9) < 6;
    s.motion_level = 16'($urandom);
    return s;
  endfunction

  function automatic bam_pkg::in_t one_sample(input logic [4:0] p, input logic [15:0] hr,
                                              input logic [15:0] hrv, input logic [15:0] c,
                                              input logic [15:0] t, input logic [15:0] m);
    return '{p[0], hr, p[1], hrv, p[2], c, p[3], t, p[4], m};
  endfunction

  initial begin
    for (int f = 0; f < bam_pkg::NFIELDS; f++) begin
      win_sum[f] = 0;
      win_cnt[f] = 0;
    end
    win_slot = 0;
    win_fill = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Disabled: neutral answers, window untouched.
    write_enable(1'b0);
    repeat (6) queue_sample(random_sample());
    queue_sample(one_sample(5'h1f, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff));
    drain();

    // Directed: breakpoints of each map, saturation and the field extremes.
    write_enable(1'b1);
    queue_sample(one_sample(5'h00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h1f, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h1f, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff));
    queue_sample(one_sample(5'h1f, 16'd3839, 16'd1279, 16'd5119, 16'h8000, 16'hffff));
    queue_sample(one_sample(5'h01, 16'd3840, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h01, 16'd5119, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h01, 16'd5120, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h01, 16'd6399, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h01, 16'd6400, 16'd0, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h03, 16'd7168, 16'd1280, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h03, 16'd7200, 16'd2560, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h03, 16'd6000, 16'd2561, 16'd0, 16'd0, 16'd0));
    queue_sample(one_sample(5'h06, 16'd0, 16'd3839, 16'd5120, 16'd0, 16'd0));
    queue_sample(one_sample(5'h06, 16'd0, 16'd3840, 16'd5121, 16'd0, 16'd0));
    queue_sample(one_sample(5'h04, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0));
    queue_sample(one_sample(5'h08, 16'd0, 16'd0, 16'd0, 16'd9216, 16'd0));
    queue_sample(one_sample(5'h08, 16'd0, 16'd0, 16'd0, 16'd9727, 16'd0));
    queue_sample(one_sample(5'h08, 16'd0, 16'd0, 16'd0, 16'd8704, 16'd0));
    queue_sample(one_sample(5'h10, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff));
    queue_sample(one_sample(5'h11, 16'hffff, 16'd0, 16'd0, 16'd0, 16'h8000));
    repeat (500) queue_sample(random_sample());
    drain();

    // A disabled stretch in the middle must leave the window as it was.
    write_enable(1'b0);
    repeat (30) queue_sample(random_sample());
    drain();
    write_enable(1'b1);
    repeat (500) queue_sample(random_sample());
    drain();
    repeat (200) @(posedge clk_i);

    $display("tb: %0d samples sent, %0d results checked, through both enable settings,",
             samples_sent, results_seen);
    $display("tb: map breakpoints, saturation, window wrap and a long output hold-off.");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
